FILE: src/oas_pkg.sv
// Shared types and constants for the obstacle avoidance supervisor.
`default_nettype none

package oas_pkg;

  typedef enum logic [1:0] {
    STRAT_STOP   = 2'd0,
    STRAT_ACTION = 2'd1,
    STRAT_NORMAL = 2'd2,
    STRAT_DELAY  = 2'd3
  } strategy_t;

  typedef enum logic [1:0] {
    SOUND_NONE  = 2'd0,
    SOUND_SHORT = 2'd1,
    SOUND_LONG  = 2'd2
  } sound_t;

  localparam logic [15:0] HOLD_STOP     = 16'd20;
  localparam logic [15:0] HOLD_ACTION   = 16'd40;
  localparam logic [7:0]  CLEAR_STOP    = 8'd100;
  localparam logic [7:0]  CLEAR_DELAY   = 8'd50;
  localparam logic [15:0] FRONT_TIMEOUT = 16'd200;
  localparam logic [15:0] REAR_TIMEOUT  = 16'd2;
  localparam logic [9:0]  RIGHT_TOP     = 10'd500;
  localparam logic [9:0]  RIGHT_BOTTOM  = 10'd400;
  localparam logic [7:0]  LEFT_TOP      = 8'd200;
  localparam logic [7:0]  LEFT_BOTTOM   = 8'd100;
  localparam logic [9:0]  RIGHT_STEP    = 10'd10;
  localparam logic [7:0]  LEFT_STEP     = 8'd10;

  // Input item, 48 bits; first member is the top bits.
  typedef struct packed {
    logic [6:0]  pad;
    logic        sweep_enable;
    logic [15:0] match_seconds;
    logic [15:0] period_ticks;
    logic        rear_right_sensor;
    logic        rear_left_sensor;
    logic        front_left_sensor;
    logic        front_right_sensor;
    strategy_t   strategy;
    logic        rear_enable;
    logic        front_enable;
  } in_item_t;

  // Result item, 32 bits.
  typedef struct packed {
    logic [6:0] pad;
    logic [7:0] sweep_left_pos;
    logic [8:0] sweep_right_pos;
    logic       sweep_valid;
    logic       detecting;
    sound_t     sound_code;
    logic       avoid_error;
    logic       end_move_cmd;
    logic       release_cmd;
    logic       brake_cmd;
  } out_item_t;

  // Servo targets after one sweep step.
  typedef struct packed {
    logic [8:0] right_pos;
    logic [7:0] left_pos;
  } sweep_pos_t;

endpackage

`default_nettype wire

FILE: src/obstacle_avoidance_supervisor_unit.sv
// Top level of the obstacle avoidance supervisor: tick register, decision logic, result register.
//
//   channel   dir  width  content
//   s_axis    in   48     one 10 ms tick: enables, strategy, sensors, counters, sweep enable
//   m_axis    out  32     one result per tick: commands, sound, detection flag, servo targets
//
// One item per clock while m_axis is ready; each tick passes through the input register
// and then the result register.
// The detection state updates in the cycle a tick moves into the result register.
// rst (synchronous) clears the detection and sweep state and both valid flags; data registers are not reset.
// A stalled m_axis holds its result; s_axis keeps accepting while the input
// register is empty or moving on.
`default_nettype none

module obstacle_avoidance_supervisor_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [0] front_enable [1] rear_enable [3:2] strategy [4] front_right_sensor
  // [5] front_left_sensor [6] rear_left_sensor [7] rear_right_sensor
  // [23:8] period_ticks [39:24] match_seconds [40] sweep_enable [47:41] zero
  input  wire logic [47:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] brake_cmd [1] release_cmd [2] end_move_cmd [3] avoid_error [5:4] sound_code
  // [6] detecting [7] sweep_valid [16:8] sweep_right_pos [24:17] sweep_left_pos [31:25] zero
  output logic [31:0]      m_axis_tdata
);
  import oas_pkg::*;

  logic      in_valid;
  in_item_t  in_q;
  logic      advance;

  logic        detection_flag, detection_flag_next;
  logic [15:0] hold_count, hold_count_next;
  logic [7:0]  clear_count, clear_count_next;
  logic [15:0] start_stamp, start_stamp_next;
  logic        avoid_running, avoid_running_next;

  logic        seen, clear;
  logic [15:0] now, limit, elapsed;
  logic        sweep_step;
  sweep_pos_t  sweep_pos;
  out_item_t   res, out_q;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tdata  = out_q;

  always_comb begin
    detection_flag_next = detection_flag;
    hold_count_next     = hold_count;
    clear_count_next    = clear_count;
    start_stamp_next    = start_stamp;
    avoid_running_next  = avoid_running;
    res                 = '0;
    res.sound_code      = SOUND_NONE;
    sweep_step          = 1'b0;

    if (in_q.front_enable) begin
      seen  = !in_q.front_right_sensor || !in_q.front_left_sensor;
      clear = in_q.front_right_sensor && in_q.front_left_sensor;
      now   = in_q.period_ticks;
      limit = FRONT_TIMEOUT;
    end else begin
      seen  = in_q.rear_left_sensor || in_q.rear_right_sensor;
      clear = !in_q.rear_left_sensor && !in_q.rear_right_sensor;
      now   = in_q.match_seconds;
      limit = REAR_TIMEOUT;
    end
    elapsed = now - start_stamp;

    if (in_q.front_enable || in_q.rear_enable) begin
      if (seen && !detection_flag) begin
        hold_count_next     = '0;
        clear_count_next    = '0;
        start_stamp_next    = now;
        avoid_running_next  = 1'b0;
        res.avoid_error     = (in_q.strategy != STRAT_DELAY);
        detection_flag_next = 1'b1;
        res.brake_cmd       = 1'b1;
      end else if (detection_flag) begin
        case (in_q.strategy)
          STRAT_STOP: begin
            hold_count_next = hold_count + 16'd1;
            if (hold_count_next > HOLD_STOP) begin
              clear_count_next = clear ? clear_count + 8'd1 : 8'd0;
              if (clear_count_next > CLEAR_STOP) begin
                // front side restarts the debounce, rear side keeps it
                if (in_q.front_enable) clear_count_next = '0;
                detection_flag_next = 1'b0;
                res.release_cmd     = 1'b1;
              end
            end
          end
          STRAT_ACTION, STRAT_NORMAL: begin
            if (!avoid_running) begin
              hold_count_next = hold_count + 16'd1;
              if (hold_count_next > HOLD_ACTION) begin
                avoid_running_next = 1'b1;
                hold_count_next    = '0;
                res.end_move_cmd   = 1'b1;
                if (!in_q.front_enable) res.sound_code = SOUND_LONG;
              end else if (!in_q.front_enable) begin
                res.sound_code = SOUND_SHORT;
              end
            end
          end
          STRAT_DELAY: begin
            clear_count_next = clear ? clear_count + 8'd1 : 8'd0;
            if (clear_count_next > CLEAR_DELAY) begin
              detection_flag_next = 1'b0;
              res.release_cmd     = 1'b1;
            end
            if (elapsed > limit) begin
              res.avoid_error  = 1'b1;
              res.end_move_cmd = 1'b1;
            end
          end
          default: begin
            res.sound_code = SOUND_NONE;
          end
        endcase
      end
      sweep_step = in_q.front_enable && in_q.sweep_enable;
    end else if (detection_flag) begin
      detection_flag_next = 1'b0;
      res.release_cmd     = 1'b1;
    end

    res.detecting   = detection_flag_next;
    res.sweep_valid = sweep_step;
    if (sweep_step) begin
      res.sweep_right_pos = sweep_pos.right_pos;
      res.sweep_left_pos  = sweep_pos.left_pos;
    end
  end

  oas_sweep u_sweep (
    .clk  (clk),
    .rst  (rst),
    .step (advance && sweep_step),
    .pos  (sweep_pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid       <= 1'b0;
      m_axis_tvalid  <= 1'b0;
      detection_flag <= 1'b0;
      hold_count     <= '0;
      clear_count    <= '0;
      start_stamp    <= '0;
      avoid_running  <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid <= s_axis_tvalid;
      if (advance) begin
        m_axis_tvalid  <= 1'b1;
        detection_flag <= detection_flag_next;
        hold_count     <= hold_count_next;
        clear_count    <= clear_count_next;
        start_stamp    <= start_stamp_next;
        avoid_running  <= avoid_running_next;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) in_q <= in_item_t'(s_axis_tdata);
    if (advance) out_q <= res;
  end

endmodule

`default_nettype wire

FILE: src/oas_sweep.sv
// Triangle sweep of the two front sensor servos, one step per stepped item.
`default_nettype none

module oas_sweep (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  output oas_pkg::sweep_pos_t     pos
);
  import oas_pkg::*;

  logic       right_down, right_down_next;
  logic       left_down, left_down_next;
  logic [9:0] right_angle, right_angle_next;
  logic [7:0] left_angle, left_angle_next;

  always_comb begin
    if (!right_down) begin
      right_angle_next = right_angle + RIGHT_STEP;
      right_down_next  = (right_angle_next > RIGHT_TOP);
    end else begin
      right_angle_next = right_angle - RIGHT_STEP;
      right_down_next  = !(right_angle_next < RIGHT_BOTTOM);
    end
    if (!left_down) begin
      left_angle_next = left_angle + LEFT_STEP;
      left_down_next  = (left_angle_next > LEFT_TOP);
    end else begin
      left_angle_next = left_angle - LEFT_STEP;
      left_down_next  = !(left_angle_next < LEFT_BOTTOM);
    end
  end

  assign pos.right_pos = right_angle_next[8:0];
  assign pos.left_pos  = left_angle_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      right_down  <= 1'b0;
      left_down   <= 1'b0;
      right_angle <= '0;
      left_angle  <= '0;
    end else if (step) begin
      right_down  <= right_down_next;
      left_down   <= left_down_next;
      right_angle <= right_angle_next;
      left_angle  <= left_angle_next;
    end
  end

endmodule

`default_nettype wire
